[sv/euclidean_access_code_detector_macros.svh]
// Assertion macros shared by the access code detector sources.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef EUCLIDEAN_ACCESS_CODE_DETECTOR_MACROS_SVH
`define EUCLIDEAN_ACCESS_CODE_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EACD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EACD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/eacd_pkg.sv]
// Package for the access code detector: fixed widths, register indexes,
// sequencer states and the control struct. No dependencies.
package eacd_pkg;

    localparam int SC_W      = 7;
    localparam int BPS_W     = 2;
    localparam int CODE_W    = 64;
    localparam int DIST_W    = 38;
    localparam int ROOT_W    = 19;
    localparam int FRAC_BITS = 12;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_SYMBOL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_WORD       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD       = 2'd3;

    // Code level 2*s - (2^bps - 1), range -3..3.
    typedef logic signed [3:0] t_level;

    typedef struct packed {
        logic clear;
        logic issue;
    } t_mac_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_ROOT,
        S_HOLD
    } t_state;

endpackage

[sv/eacd_if.sv]
// Valid/ready channel interfaces for the access code detector.
// Depends on eacd_pkg for the result field widths.
interface eacd_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface eacd_out_if #(
    parameter int SAMPLE_WIDTH = 16
);
    import eacd_pkg::*;

    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           match;
    logic [DIST_W-1:0]              distance_squared;
    logic [ROOT_W-1:0]              distance_root;

    modport source (output valid, output sample_out, output match,
                    output distance_squared, output distance_root, input ready);
    modport sink   (input valid, input sample_out, input match,
                    input distance_squared, input distance_root, output ready);
endinterface

[sv/eacd_window.sv]
// Sample history kept as a circular buffer in a memory with per-entry valid bits.
// Depends on eacd_pkg (imported for house consistency).
module eacd_window #(
    parameter int MAX_SYMBOLS  = 64,
    parameter int SAMPLE_WIDTH = 16,
    parameter int AW           = 6
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_we,
    input  logic signed [SAMPLE_WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]                  i_age,
    output logic signed [SAMPLE_WIDTH-1:0] o_rdata
);
    import eacd_pkg::*;

    localparam logic [AW:0]   DEPTH   = (AW+1)'(MAX_SYMBOLS);
    localparam logic [AW-1:0] LAST_WP = AW'(MAX_SYMBOLS - 1);

    logic signed [SAMPLE_WIDTH-1:0] r_mem [MAX_SYMBOLS];
    logic [MAX_SYMBOLS-1:0]         r_vld;
    logic [AW-1:0]                  r_wp;
    logic signed [SAMPLE_WIDTH-1:0] r_rdata;
    logic                           r_rvld;
    logic [AW:0]                    w_base;
    logic [AW-1:0]                  w_raddr;

    // The newest sample sits just below the write pointer; age counts back from it.
    always_comb begin
        w_base = {1'b0, r_wp} + DEPTH - (AW+1)'(1) - {1'b0, i_age};
        if (w_base >= DEPTH) begin
            w_base = w_base - DEPTH;
        end
        w_raddr = w_base[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[r_wp] <= i_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_wp   <= '0;
            r_rvld <= 1'b0;
        end else begin
            r_rvld <= r_vld[w_raddr];
            if (i_we) begin
                r_vld[r_wp] <= 1'b1;
                r_wp        <= (r_wp == LAST_WP) ? '0 : r_wp + AW'(1);
            end
        end
    end

    // Entries never written read as the reset value of zero.
    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

[sv/eacd_mac.sv]
// Shared square-and-accumulate unit: one window entry per cycle, saturating sum.
// Depends on eacd_pkg for the level type, control struct and distance width.
module eacd_mac #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  eacd_pkg::t_mac_ctl             i_ctl,
    input  eacd_pkg::t_level               i_level,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic [eacd_pkg::DIST_W-1:0]    o_sum,
    output logic                           o_busy
);
    import eacd_pkg::*;

    localparam int DW = (SAMPLE_WIDTH < 15) ? 16 : SAMPLE_WIDTH + 1;
    localparam int PW = 2 * DW - 1;
    localparam int SW = ((DIST_W > PW) ? DIST_W : PW) + 1;

    t_level               r_level;
    logic                 r_v1;
    logic                 r_v2;
    logic [PW-1:0]        r_prod;
    logic [DIST_W-1:0]    r_sum;
    logic signed [DW-1:0] w_ref;
    logic signed [DW-1:0] w_diff;
    logic signed [2*DW-1:0] w_sq;
    logic [SW-1:0]        w_acc;
    logic [DIST_W-1:0]    n_sum;

    always_comb begin
        w_ref  = $signed({{(DW-4){r_level[3]}}, r_level}) <<< FRAC_BITS;
        w_diff = w_ref - DW'(i_sample);
        w_sq   = w_diff * w_diff;
        w_acc  = SW'(r_sum) + SW'(r_prod);
        n_sum  = (w_acc > SW'(DIST_MAX)) ? DIST_MAX : w_acc[DIST_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_level <= i_level;
        r_prod  <= w_sq[PW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_sum <= '0;
        end else begin
            r_v1 <= i_ctl.issue;
            r_v2 <= r_v1;
            if (i_ctl.clear) begin
                r_sum <= '0;
            end else if (r_v2) begin
                r_sum <= n_sum;
            end
        end
    end

    assign o_sum  = r_sum;
    assign o_busy = r_v1 | r_v2;

endmodule

[sv/eacd_isqrt.sv]
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on eacd_pkg for the distance and root widths.
module eacd_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [eacd_pkg::DIST_W-1:0] i_value,
    output logic                        o_busy,
    output logic [eacd_pkg::ROOT_W-1:0] o_root
);
    import eacd_pkg::*;

    localparam logic [DIST_W-1:0] BIT_INIT = DIST_W'(1) << (2 * (ROOT_W - 1));

    logic [DIST_W-1:0] r_rem;
    logic [DIST_W-1:0] r_res;
    logic [DIST_W-1:0] r_bit;
    logic [DIST_W-1:0] w_trial;
    logic [DIST_W-1:0] n_rem;
    logic [DIST_W-1:0] n_res;

    always_comb begin
        w_trial = r_res + r_bit;
        if (r_rem >= w_trial) begin
            n_rem = r_rem - w_trial;
            n_res = (r_res >> 1) + r_bit;
        end else begin
            n_rem = r_rem;
            n_res = r_res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_value;
            r_res <= '0;
        end else if (o_busy) begin
            r_rem <= n_rem;
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= '0;
        end else if (i_start) begin
            r_bit <= BIT_INIT;
        end else begin
            r_bit <= r_bit >> 2;
        end
    end

    assign o_busy = (r_bit != '0);
    assign o_root = r_res[ROOT_W-1:0];

endmodule

[sv/euclidean_access_code_detector.sv]
// Access code detector top level: configuration registers, sequencer, output register.
// Depends on eacd_pkg, eacd_if, eacd_window, eacd_mac, eacd_isqrt and the macros header.
//
// Usage: soft symbols enter on the sample channel (valid/ready), one item per symbol.
// Each item leaves on the result channel carrying the sample itself, the squared
// Euclidean distance between the code levels and the symbol_count samples that came
// before it, the integer square root of that distance and the match flag.
// The square-and-accumulate unit visits one window entry per cycle, reading the sample
// memory through its single read port, and the square root unit resolves one bit per
// cycle. The block takes a new item only when the previous one is through.
// The result sits in an output register: a new item is taken while an earlier result
// waits, and when the receiver stalls the sequencer holds its finished result until
// that register frees. Reset empties the sample history (it reads as zeros) and loads
// the default configuration. Configuration is written through the plain write port;
// the user must do so only while no item is in flight, as the block does not enforce it.
module euclidean_access_code_detector #(
    parameter int MAX_SYMBOLS  = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    eacd_in_if.sink                        i_sample_ch,
    eacd_out_if.source                     o_result_ch,
    input  logic                           i_cfg_we,
    input  logic [eacd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [eacd_pkg::CODE_W-1:0]    i_cfg_data
);
    import eacd_pkg::*;

    `include "euclidean_access_code_detector_macros.svh"

    localparam int AW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam logic [SC_W-1:0] MAX_N = SC_W'(MAX_SYMBOLS);

    // Configuration registers.
    logic [SC_W-1:0]   r_symbol_count;
    logic [BPS_W-1:0]  r_bits_per_symbol;
    logic [CODE_W-1:0] r_code_word;
    logic [DIST_W-1:0] r_threshold;

    t_state r_state;
    t_state n_state;

    logic [SC_W-1:0]                r_age;
    logic signed [SAMPLE_WIDTH-1:0] r_sample;

    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_sample;
    logic                           r_out_match;
    logic [DIST_W-1:0]              r_out_dist;
    logic [ROOT_W-1:0]              r_out_root;

    logic [SC_W-1:0]                w_n;
    logic                           w_bps2;
    logic [SC_W:0]                  w_idx;
    logic                           w_bit0;
    logic                           w_bit1;
    t_level                         w_level;
    logic                           w_accept;
    logic                           w_out_free;
    t_mac_ctl                       w_mac_ctl;
    logic                           w_root_start;
    logic                           w_load_out;
    logic                           w_ready;
    logic signed [SAMPLE_WIDTH-1:0] w_win_data;
    logic [DIST_W-1:0]              w_sum;
    logic                           w_mac_busy;
    logic                           w_root_busy;
    logic [ROOT_W-1:0]              w_root;

    // Out-of-range counts clamp into 1..MAX_SYMBOLS.
    always_comb begin
        if (r_symbol_count == '0) begin
            w_n = SC_W'(1);
        end else if (r_symbol_count > MAX_N) begin
            w_n = MAX_N;
        end else begin
            w_n = r_symbol_count;
        end
    end

    // Symbol at a given age starts at code bit age*bps; bits past the word read as zero.
    always_comb begin
        w_bps2 = r_bits_per_symbol[1];
        w_idx  = w_bps2 ? {r_age, 1'b0} : {1'b0, r_age};
        w_bit0 = (w_idx < (SC_W+1)'(CODE_W)) ? r_code_word[w_idx[5:0]] : 1'b0;
        w_bit1 = (w_bps2 && (w_idx < (SC_W+1)'(CODE_W))) ?
                 r_code_word[{w_idx[5:1], 1'b1}] : 1'b0;
        if (w_bps2) begin
            w_level = $signed({1'b0, w_bit1, w_bit0, 1'b0}) - t_level'(3);
        end else begin
            w_level = $signed({2'b00, w_bit0, 1'b0}) - t_level'(1);
        end
    end

    assign w_accept   = i_sample_ch.valid && w_ready;
    assign w_out_free = !r_out_valid || o_result_ch.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_sample_ch.valid) n_state = S_RUN;
            S_RUN:   if (r_age == '0) n_state = S_DRAIN;
            S_DRAIN: if (!w_mac_busy) n_state = S_ROOT;
            S_ROOT:  if (!w_root_busy) n_state = S_HOLD;
            S_HOLD:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_ready         = 1'b0;
        w_mac_ctl.clear = 1'b0;
        w_mac_ctl.issue = 1'b0;
        w_root_start    = 1'b0;
        w_load_out      = 1'b0;
        case (r_state)
            S_IDLE: begin
                w_ready         = 1'b1;
                w_mac_ctl.clear = i_sample_ch.valid;
            end
            S_RUN:   w_mac_ctl.issue = 1'b1;
            S_DRAIN: w_root_start = !w_mac_busy;
            S_ROOT:  ;
            S_HOLD:  w_load_out = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= i_sample_ch.sample_in;
            r_age    <= w_n - SC_W'(1);
        end else if (r_state == S_RUN && r_age != '0) begin
            r_age <= r_age - SC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_count    <= SC_W'(64);
            r_bits_per_symbol <= BPS_W'(1);
            r_code_word       <= '0;
            r_threshold       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SYMBOL_COUNT:    r_symbol_count    <= i_cfg_data[SC_W-1:0];
                CFG_BITS_PER_SYMBOL: r_bits_per_symbol <= i_cfg_data[BPS_W-1:0];
                CFG_CODE_WORD:       r_code_word       <= i_cfg_data;
                CFG_THRESHOLD:       r_threshold       <= i_cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_result_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_sample <= r_sample;
            r_out_match  <= (w_sum <= r_threshold);
            r_out_dist   <= w_sum;
            r_out_root   <= w_root;
        end
    end

    eacd_window #(
        .MAX_SYMBOLS  (MAX_SYMBOLS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .AW           (AW)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_load_out),
        .i_wdata (r_sample),
        .i_age   (r_age[AW-1:0]),
        .o_rdata (w_win_data)
    );

    eacd_mac #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mac_ctl),
        .i_level  (w_level),
        .i_sample (w_win_data),
        .o_sum    (w_sum),
        .o_busy   (w_mac_busy)
    );

    eacd_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_start),
        .i_value (w_sum),
        .o_busy  (w_root_busy),
        .o_root  (w_root)
    );

    assign i_sample_ch.ready            = w_ready;
    assign o_result_ch.valid            = r_out_valid;
    assign o_result_ch.sample_out       = r_out_sample;
    assign o_result_ch.match            = r_out_match;
    assign o_result_ch.distance_squared = r_out_dist;
    assign o_result_ch.distance_root    = r_out_root;

    `EACD_ASSERT_NEXT(a_accept_starts_run, i_clk, i_rst_n, w_accept,
        r_state == S_RUN, "accepted item did not start the window pass")
    `EACD_ASSERT_NOW(a_mac_busy_in_pass, i_clk, i_rst_n, w_mac_busy,
        r_state == S_RUN || r_state == S_DRAIN, "accumulator busy outside the window pass")
    `EACD_ASSERT_NOW(a_root_busy_in_root, i_clk, i_rst_n, w_root_busy,
        r_state == S_ROOT, "square root unit busy outside its state")
    `EACD_ASSERT_NOW(a_match_consistent, i_clk, i_rst_n, r_out_valid,
        r_out_match == (r_out_dist <= r_threshold), "match flag disagrees with distance")

endmodule
